// ===== src/hiwa_pkg.sv =====
// Package with the shared types, fixed-point constants and states of the heat index averager.
`timescale 1ns / 1ps

package hiwa_pkg;

  // Signed fixed-point operand of the shared arithmetic units.
  typedef logic signed [47:0] fx_t;

  // Window length register.
  localparam logic [4:0] WIN_RESET = 5'd10;
  localparam logic [4:0] WIN_MAX   = 5'd16;

  // Offsets in degrees F, Q16.
  localparam fx_t OFS_32F = 48'sd2097152;
  localparam fx_t OFS_61F = 48'sd3997696;
  localparam fx_t OFS_68F = 48'sd4456448;
  localparam fx_t THR_80F = 48'sd5242880;

  // Scale factors and divisors.
  localparam fx_t        K_T_SCALE  = 48'sd589824;
  localparam fx_t        K_FIFTY    = 48'sd50;
  localparam logic [19:0] D_FIFTY   = 20'd50;
  localparam logic [19:0] D_TEN     = 20'd10;
  localparam logic [19:0] D_NINE_Q16 = 20'd589824;

  // Simple formula coefficients, Q32.
  localparam fx_t K_ONE_TWO    = 48'sd5153960755;
  localparam fx_t K_HUM_SIMPLE = 48'sd403726926;

  // Rothfusz regression coefficients; the constant term is Q16, the others Q32.
  localparam fx_t R_C1 = -48'sd2777350;
  localparam fx_t R_C2 = 48'sd8800453402;
  localparam fx_t R_C3 = 48'sd43565276077;
  localparam fx_t R_C4 = -48'sd965317136;
  localparam fx_t R_C5 = -48'sd29368256;
  localparam fx_t R_C6 = -48'sd235437952;
  localparam fx_t R_C7 = 48'sd5277398;
  localparam fx_t R_C8 = 48'sd3662834;
  localparam fx_t R_C9 = -48'sd8547;

  // Heat index saturation limits in tenths of degree C.
  localparam fx_t HI_MIN = -48'sd1000;
  localparam fx_t HI_MAX = 48'sd3000;

  // Rounding shift applied to a product.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_Q16,
    SH_Q32
  } mul_shift_e;

  // Request from the sequencer to the serial multiplier.
  typedef struct packed {
    logic       start;
    mul_shift_e shift;
  } mul_req_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TMUL,
    ST_TDIV,
    ST_HDIV,
    ST_S1,
    ST_S2,
    ST_SCHK,
    ST_R2,
    ST_R3,
    ST_TT,
    ST_R5,
    ST_HH,
    ST_R6,
    ST_TH,
    ST_R4,
    ST_TTH,
    ST_R7,
    ST_THH,
    ST_R8,
    ST_TTHH,
    ST_R9,
    ST_CMUL,
    ST_CDIV,
    ST_ACC,
    ST_AVT,
    ST_AVH,
    ST_AVI,
    ST_OUT
  } ctrl_state_e;

endpackage

// ===== src/hiwa_if.sv =====
// Handshake interfaces for the reading input channel and the average output channel.
`timescale 1ns / 1ps

interface hiwa_in_if;
  logic               valid;
  logic               ready;
  logic               reading_ok;
  logic signed [10:0] temp_tenths;
  logic        [9:0]  hum_tenths;

  modport source (output valid, reading_ok, temp_tenths, hum_tenths, input ready);
  modport sink   (input valid, reading_ok, temp_tenths, hum_tenths, output ready);
endinterface

interface hiwa_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] avg_temp_tenths;
  logic        [9:0]  avg_hum_tenths;
  logic signed [12:0] avg_heat_index_tenths;
  logic        [4:0]  valid_count;

  modport source (output valid, avg_temp_tenths, avg_hum_tenths, avg_heat_index_tenths,
                  valid_count, input ready);
  modport sink   (input valid, avg_temp_tenths, avg_hum_tenths, avg_heat_index_tenths,
                  valid_count, output ready);
endinterface

// ===== src/heat_index_window_averager_unit.sv =====
// Top level of the heat index window averager: sequencer, window sums and output register.
//
// Readings enter on in_i as words; in_i.ready is high only while the sequencer is idle, so
// one reading is worked on at a time. A failed reading skips the arithmetic. A valid reading
// runs the temperature and humidity conversions, the simple formula and the conversion
// back to degrees C through one bit-serial multiplier and one bit-serial divider, and
// the nine-term regression too when it applies. Each multiply steps through the bits of
// its second operand, each divide through the bits of its numerator.
// When a window closes with valid readings, three averaging divides follow and the result
// word is loaded into the output register on out_o.
// If the receiver stalls, the result word waits in that register; the block accepts the
// next reading meanwhile and stalls only if a second window closes before the first
// result is taken.
// cfg_we_i writes cfg_wdata_i into the window length (0 acts as 1, above 16 as 16).
// Reset clears the sums and counters, empties the output register and sets the window
// length to 10.
`timescale 1ns / 1ps

module heat_index_window_averager_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  hiwa_in_if.sink     in_i,
  hiwa_out_if.source  out_o
);

  hiwa_pkg::ctrl_state_e state_q, state_d;
  logic                  issued_q, issued_d;
  logic [4:0]            win_q;
  logic                  ok_q, ok_d;
  logic signed [10:0]    tin_q, tin_d;
  logic [9:0]            hin_q, hin_d;
  hiwa_pkg::fx_t         t_q, t_d, h_q, h_d, tt_q, tt_d, hh_q, hh_d;
  hiwa_pkg::fx_t         p_q, p_d, acc_q, acc_d;
  logic signed [12:0]    hidx_q, hidx_d;
  logic signed [14:0]    tsum_q, tsum_d;
  logic [13:0]           hsum_q, hsum_d;
  logic signed [16:0]    isum_q, isum_d;
  logic [4:0]            good_q, good_d;
  logic [4:0]            att_q, att_d;
  logic signed [10:0]    avgt_q, avgt_d;
  logic [9:0]            avgh_q, avgh_d;
  logic signed [12:0]    avgi_q, avgi_d;
  logic                  ov_q, ov_d;
  logic signed [10:0]    ot_q, ot_d;
  logic [9:0]            oh_q, oh_d;
  logic signed [12:0]    oi_q, oi_d;
  logic [4:0]            on_q, on_d;

  hiwa_pkg::mul_req_t    mul_req;
  hiwa_pkg::fx_t         mul_a, mul_b, mul_p;
  logic                  mul_busy, mul_done;
  logic                  div_start, div_busy, div_done;
  hiwa_pkg::fx_t         div_n, div_q;
  logic [19:0]           div_d;
  logic                  in_acc;

  assign in_acc = in_i.valid && in_i.ready;

  // Window length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= hiwa_pkg::WIN_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Control state and window counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hiwa_pkg::ST_IDLE;
      issued_q <= 1'b0;
      tsum_q   <= '0;
      hsum_q   <= '0;
      isum_q   <= '0;
      good_q   <= '0;
      att_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      tsum_q   <= tsum_d;
      hsum_q   <= hsum_d;
      isum_q   <= isum_d;
      good_q   <= good_d;
      att_q    <= att_d;
      ov_q     <= ov_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    tin_q  <= tin_d;
    hin_q  <= hin_d;
    t_q    <= t_d;
    h_q    <= h_d;
    tt_q   <= tt_d;
    hh_q   <= hh_d;
    p_q    <= p_d;
    acc_q  <= acc_d;
    hidx_q <= hidx_d;
    avgt_q <= avgt_d;
    avgh_q <= avgh_d;
    avgi_q <= avgi_d;
    ot_q   <= ot_d;
    oh_q   <= oh_d;
    oi_q   <= oi_d;
    on_q   <= on_d;
  end

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    logic use_mul;
    logic use_div;
    use_mul       = 1'b1;
    use_div       = 1'b0;
    mul_a         = t_q;
    mul_b         = t_q;
    mul_req.shift = hiwa_pkg::SH_Q32;
    div_n         = p_q;
    div_d         = hiwa_pkg::D_FIFTY;
    unique case (state_q)
      hiwa_pkg::ST_TMUL: begin
        mul_a         = {{37{tin_q[10]}}, tin_q};
        mul_b         = hiwa_pkg::K_T_SCALE;
        mul_req.shift = hiwa_pkg::SH_NONE;
      end
      hiwa_pkg::ST_S1: begin
        mul_a = t_q - hiwa_pkg::OFS_68F;
        mul_b = hiwa_pkg::K_ONE_TWO;
      end
      hiwa_pkg::ST_S2: begin mul_a = h_q;  mul_b = hiwa_pkg::K_HUM_SIMPLE; end
      hiwa_pkg::ST_R2: begin mul_a = t_q;  mul_b = hiwa_pkg::R_C2; end
      hiwa_pkg::ST_R3: begin mul_a = h_q;  mul_b = hiwa_pkg::R_C3; end
      hiwa_pkg::ST_R4: begin mul_a = p_q;  mul_b = hiwa_pkg::R_C4; end
      hiwa_pkg::ST_R5: begin mul_a = tt_q; mul_b = hiwa_pkg::R_C5; end
      hiwa_pkg::ST_R6: begin mul_a = hh_q; mul_b = hiwa_pkg::R_C6; end
      hiwa_pkg::ST_R7: begin mul_a = p_q;  mul_b = hiwa_pkg::R_C7; end
      hiwa_pkg::ST_R8: begin mul_a = p_q;  mul_b = hiwa_pkg::R_C8; end
      hiwa_pkg::ST_R9: begin mul_a = p_q;  mul_b = hiwa_pkg::R_C9; end
      hiwa_pkg::ST_TT: begin
        mul_a = t_q;  mul_b = t_q;  mul_req.shift = hiwa_pkg::SH_Q16;
      end
      hiwa_pkg::ST_HH: begin
        mul_a = h_q;  mul_b = h_q;  mul_req.shift = hiwa_pkg::SH_Q16;
      end
      hiwa_pkg::ST_TH: begin
        mul_a = t_q;  mul_b = h_q;  mul_req.shift = hiwa_pkg::SH_Q16;
      end
      hiwa_pkg::ST_TTH: begin
        mul_a = tt_q; mul_b = h_q;  mul_req.shift = hiwa_pkg::SH_Q16;
      end
      hiwa_pkg::ST_THH: begin
        mul_a = t_q;  mul_b = hh_q; mul_req.shift = hiwa_pkg::SH_Q16;
      end
      hiwa_pkg::ST_TTHH: begin
        mul_a = tt_q; mul_b = hh_q; mul_req.shift = hiwa_pkg::SH_Q16;
      end
      hiwa_pkg::ST_CMUL: begin
        mul_a         = acc_q - hiwa_pkg::OFS_32F;
        mul_b         = hiwa_pkg::K_FIFTY;
        mul_req.shift = hiwa_pkg::SH_NONE;
      end
      hiwa_pkg::ST_TDIV: begin
        use_mul = 1'b0; use_div = 1'b1;
      end
      hiwa_pkg::ST_HDIV: begin
        use_mul = 1'b0; use_div = 1'b1;
        div_n   = {22'b0, hin_q, 16'b0};
        div_d   = hiwa_pkg::D_TEN;
      end
      hiwa_pkg::ST_CDIV: begin
        use_mul = 1'b0; use_div = 1'b1;
        div_d   = hiwa_pkg::D_NINE_Q16;
      end
      hiwa_pkg::ST_AVT: begin
        use_mul = 1'b0; use_div = 1'b1;
        div_n   = {{33{tsum_q[14]}}, tsum_q};
        div_d   = {15'b0, good_q};
      end
      hiwa_pkg::ST_AVH: begin
        use_mul = 1'b0; use_div = 1'b1;
        div_n   = {34'b0, hsum_q};
        div_d   = {15'b0, good_q};
      end
      hiwa_pkg::ST_AVI: begin
        use_mul = 1'b0; use_div = 1'b1;
        div_n   = {{31{isum_q[16]}}, isum_q};
        div_d   = {15'b0, good_q};
      end
      default: begin
        use_mul = 1'b0;
      end
    endcase
    mul_req.start = use_mul && !issued_q;
    div_start     = use_div && !issued_q;
  end

  // Sequencer: next state and register updates.
  always_comb begin
    hiwa_pkg::fx_t res;
    hiwa_pkg::fx_t half_up;
    hiwa_pkg::fx_t hi_simple;
    logic [4:0]    len;
    logic [4:0]    att_inc;
    logic [4:0]    good_inc;
    state_d  = state_q;
    issued_d = issued_q;
    ok_d     = ok_q;
    tin_d    = tin_q;
    hin_d    = hin_q;
    t_d      = t_q;
    h_d      = h_q;
    tt_d     = tt_q;
    hh_d     = hh_q;
    p_d      = p_q;
    acc_d    = acc_q;
    hidx_d   = hidx_q;
    tsum_d   = tsum_q;
    hsum_d   = hsum_q;
    isum_d   = isum_q;
    good_d   = good_q;
    att_d    = att_q;
    avgt_d   = avgt_q;
    avgh_d   = avgh_q;
    avgi_d   = avgi_q;
    ov_d     = ov_q;
    ot_d     = ot_q;
    oh_d     = oh_q;
    oi_d     = oi_q;
    on_d     = on_q;
    res      = mul_done ? mul_p : div_q;

    // Halve the simple sum with ties away from zero.
    if (acc_q[47]) begin
      half_up   = hiwa_pkg::fx_t'(-acc_q) + 48'sd1;
      hi_simple = -(half_up >>> 1);
    end else begin
      half_up   = acc_q + 48'sd1;
      hi_simple = half_up >>> 1;
    end

    // Effective window length.
    if (win_q == 5'd0) begin
      len = 5'd1;
    end else if (win_q > hiwa_pkg::WIN_MAX) begin
      len = hiwa_pkg::WIN_MAX;
    end else begin
      len = win_q;
    end
    att_inc  = att_q + 5'd1;
    good_inc = good_q + 5'd1;

    // The output register frees when its word is taken.
    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    if (mul_req.start || div_start) begin
      issued_d = 1'b1;
    end
    if (mul_done || div_done) begin
      issued_d = 1'b0;
    end

    unique case (state_q)
      hiwa_pkg::ST_IDLE: begin
        if (in_acc) begin
          ok_d    = in_i.reading_ok;
          tin_d   = in_i.temp_tenths;
          hin_d   = in_i.hum_tenths;
          state_d = in_i.reading_ok ? hiwa_pkg::ST_TMUL : hiwa_pkg::ST_ACC;
        end
      end
      hiwa_pkg::ST_TMUL: if (mul_done) begin p_d = res; state_d = hiwa_pkg::ST_TDIV; end
      hiwa_pkg::ST_TDIV: begin
        if (div_done) begin
          t_d     = res + hiwa_pkg::OFS_32F;
          state_d = hiwa_pkg::ST_HDIV;
        end
      end
      hiwa_pkg::ST_HDIV: if (div_done) begin h_d = res; state_d = hiwa_pkg::ST_S1; end
      hiwa_pkg::ST_S1: begin
        if (mul_done) begin
          acc_d   = t_q + hiwa_pkg::OFS_61F + res;
          state_d = hiwa_pkg::ST_S2;
        end
      end
      hiwa_pkg::ST_S2: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_SCHK; end
      hiwa_pkg::ST_SCHK: begin
        if (hi_simple > hiwa_pkg::THR_80F) begin
          acc_d   = hiwa_pkg::R_C1;
          state_d = hiwa_pkg::ST_R2;
        end else begin
          acc_d   = hi_simple;
          state_d = hiwa_pkg::ST_CMUL;
        end
      end
      hiwa_pkg::ST_R2: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_R3; end
      hiwa_pkg::ST_R3: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_TT; end
      hiwa_pkg::ST_TT: if (mul_done) begin tt_d = res; state_d = hiwa_pkg::ST_R5; end
      hiwa_pkg::ST_R5: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_HH; end
      hiwa_pkg::ST_HH: if (mul_done) begin hh_d = res; state_d = hiwa_pkg::ST_R6; end
      hiwa_pkg::ST_R6: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_TH; end
      hiwa_pkg::ST_TH: if (mul_done) begin p_d = res; state_d = hiwa_pkg::ST_R4; end
      hiwa_pkg::ST_R4: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_TTH; end
      hiwa_pkg::ST_TTH: if (mul_done) begin p_d = res; state_d = hiwa_pkg::ST_R7; end
      hiwa_pkg::ST_R7: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_THH; end
      hiwa_pkg::ST_THH: if (mul_done) begin p_d = res; state_d = hiwa_pkg::ST_R8; end
      hiwa_pkg::ST_R8: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_TTHH; end
      hiwa_pkg::ST_TTHH: if (mul_done) begin p_d = res; state_d = hiwa_pkg::ST_R9; end
      hiwa_pkg::ST_R9: if (mul_done) begin acc_d = acc_q + res; state_d = hiwa_pkg::ST_CMUL; end
      hiwa_pkg::ST_CMUL: if (mul_done) begin p_d = res; state_d = hiwa_pkg::ST_CDIV; end
      hiwa_pkg::ST_CDIV: begin
        if (div_done) begin
          if (res < hiwa_pkg::HI_MIN) begin
            hidx_d = 13'(hiwa_pkg::HI_MIN);
          end else if (res > hiwa_pkg::HI_MAX) begin
            hidx_d = 13'(hiwa_pkg::HI_MAX);
          end else begin
            hidx_d = res[12:0];
          end
          state_d = hiwa_pkg::ST_ACC;
        end
      end
      hiwa_pkg::ST_ACC: begin
        if (ok_q) begin
          tsum_d = tsum_q + {{4{tin_q[10]}}, tin_q};
          hsum_d = hsum_q + {4'b0, hin_q};
          isum_d = isum_q + {{4{hidx_q[12]}}, hidx_q};
          good_d = good_inc;
        end
        att_d   = att_inc;
        state_d = hiwa_pkg::ST_IDLE;
        if (att_inc >= len) begin
          if (ok_q || good_q != 5'd0) begin
            state_d = hiwa_pkg::ST_AVT;
          end else begin
            att_d = 5'd0;
          end
        end
      end
      hiwa_pkg::ST_AVT: if (div_done) begin avgt_d = res[10:0]; state_d = hiwa_pkg::ST_AVH; end
      hiwa_pkg::ST_AVH: if (div_done) begin avgh_d = res[9:0]; state_d = hiwa_pkg::ST_AVI; end
      hiwa_pkg::ST_AVI: if (div_done) begin avgi_d = res[12:0]; state_d = hiwa_pkg::ST_OUT; end
      hiwa_pkg::ST_OUT: begin
        // Load the result word once the output register is free, then clear the window.
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          ot_d    = avgt_q;
          oh_d    = avgh_q;
          oi_d    = avgi_q;
          on_d    = good_q;
          tsum_d  = '0;
          hsum_d  = '0;
          isum_d  = '0;
          good_d  = '0;
          att_d   = '0;
          state_d = hiwa_pkg::ST_IDLE;
        end
      end
      default: state_d = hiwa_pkg::ST_IDLE;
    endcase
  end

  // Shared arithmetic units.
  hiwa_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  hiwa_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Channel outputs.
  assign in_i.ready                  = (state_q == hiwa_pkg::ST_IDLE);
  assign out_o.valid                 = ov_q;
  assign out_o.avg_temp_tenths       = ot_q;
  assign out_o.avg_hum_tenths        = oh_q;
  assign out_o.avg_heat_index_tenths = oi_q;
  assign out_o.valid_count           = on_q;

  // A unit is never started while it is still working.
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The saturated heat index is within range when it is added to the sum.
  a_hidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hiwa_pkg::ST_ACC && ok_q) |->
      (hidx_q >= -13'sd1000 && hidx_q <= 13'sd3000))
    else $error("heat index out of saturation range");

  // Valid readings never outnumber attempts in a window.
  a_good_le_att: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_q <= att_q)
    else $error("valid count exceeds attempt count");

  // A result word is only loaded while the averaging path finishes.
  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == hiwa_pkg::ST_OUT)
    else $error("output loaded outside the output state");

endmodule

// ===== src/hiwa_serial_mul.sv =====
// Bit-serial shift-add multiplier with round-to-nearest rescaling of the product.
`timescale 1ns / 1ps

module hiwa_serial_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hiwa_pkg::mul_req_t req_i,
  input  hiwa_pkg::fx_t      a_i,
  input  hiwa_pkg::fx_t      b_i,
  output logic               busy_o,
  output logic               done_o,
  output hiwa_pkg::fx_t      p_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  hiwa_pkg::mul_shift_e sh_q, sh_d;
  logic [63:0]          ma_q, ma_d;
  logic [47:0]          mb_q, mb_d;
  logic [63:0]          acc_q, acc_d;
  hiwa_pkg::fx_t        p_q, p_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    sh_q  <= sh_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    p_q   <= p_d;
  end

  // One multiplier bit per cycle until none is set, then round and fix the sign.
  always_comb begin
    logic [47:0] abs_a;
    logic [47:0] abs_b;
    logic [63:0] half;
    logic [63:0] rnd;
    logic [63:0] mag;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    sh_d   = sh_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    acc_d  = acc_q;
    p_d    = p_q;
    abs_a  = a_i[47] ? 48'(-a_i) : 48'(a_i);
    abs_b  = b_i[47] ? 48'(-b_i) : 48'(b_i);
    unique case (sh_q)
      hiwa_pkg::SH_Q16: half = 64'h0000_0000_0000_8000;
      hiwa_pkg::SH_Q32: half = 64'h0000_0000_8000_0000;
      default:          half = 64'h0;
    endcase
    rnd = acc_q + half;
    unique case (sh_q)
      hiwa_pkg::SH_Q16: mag = rnd >> 16;
      hiwa_pkg::SH_Q32: mag = rnd >> 32;
      default:          mag = rnd;
    endcase
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        neg_d  = a_i[47] ^ b_i[47];
        sh_d   = req_i.shift;
        ma_d   = {16'b0, abs_a};
        mb_d   = abs_b;
        acc_d  = 64'h0;
      end
    end else if (mb_q != 48'h0) begin
      if (mb_q[0]) begin
        acc_d = acc_q + ma_q;
      end
      ma_d = {ma_q[62:0], 1'b0};
      mb_d = {1'b0, mb_q[47:1]};
    end else begin
      p_d    = neg_q ? hiwa_pkg::fx_t'(-mag[47:0]) : hiwa_pkg::fx_t'(mag[47:0]);
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== src/hiwa_serial_div.sv =====
// Bit-serial restoring divider that rounds to nearest with ties away from zero.
`timescale 1ns / 1ps

module hiwa_serial_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  hiwa_pkg::fx_t n_i,
  input  logic [19:0]   d_i,
  output logic          busy_o,
  output logic          done_o,
  output hiwa_pkg::fx_t q_o
);

  localparam int unsigned NumW = 49;
  localparam logic [5:0]  DivSteps = 6'(NumW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            neg_q, neg_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [19:0]     rem_q, rem_d;
  logic [19:0]     den_q, den_d;
  hiwa_pkg::fx_t   q_q, q_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    q_q   <= q_d;
  end

  // The numerator magnitude is biased by half the divisor, then one quotient bit per cycle.
  always_comb begin
    logic [47:0] abs_n;
    logic [20:0] rem_sh;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    q_d    = q_q;
    abs_n  = n_i[47] ? 48'(-n_i) : 48'(n_i);
    rem_sh = {rem_q, num_q[NumW-1]};
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        neg_d  = n_i[47];
        cnt_d  = DivSteps;
        num_d  = {1'b0, abs_n} + {30'b0, d_i[19:1]};
        rem_d  = 20'h0;
        den_d  = d_i;
      end
    end else if (cnt_q != 6'd0) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = 20'(rem_sh - {1'b0, den_q});
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[19:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end else begin
      q_d    = neg_q ? hiwa_pkg::fx_t'(-num_q[47:0]) : hiwa_pkg::fx_t'(num_q[47:0]);
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign q_o    = q_q;

endmodule
